>>> hdl/cse_pkg.sv
package cse_pkg;

	localparam int MAX_ELEMENTS_DEF = 32;

	localparam int OP_W  = 4;
	localparam int LEN_W = 28;
	localparam int POS_W = 31;

	// CIGAR op codes, BAM numbering.
	localparam logic [OP_W-1:0] OP_M = 4'd0;
	localparam logic [OP_W-1:0] OP_I = 4'd1;
	localparam logic [OP_W-1:0] OP_D = 4'd2;
	localparam logic [OP_W-1:0] OP_N = 4'd3;
	localparam logic [OP_W-1:0] OP_S = 4'd4;

	localparam logic [LEN_W-1:0] LEN_MAX = '1;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	// Datapath commands issued by the controller.
	localparam int CMD_W = 4;
	localparam logic [CMD_W-1:0] CMD_NONE  = 4'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD  = 4'd1;
	localparam logic [CMD_W-1:0] CMD_INIT  = 4'd2;
	localparam logic [CMD_W-1:0] CMD_FSTEP = 4'd3;
	localparam logic [CMD_W-1:0] CMD_FSOFT = 4'd4;
	localparam logic [CMD_W-1:0] CMD_FEMIT = 4'd5;
	localparam logic [CMD_W-1:0] CMD_BSTEP = 4'd6;
	localparam logic [CMD_W-1:0] CMD_BEMIT = 4'd7;
	localparam logic [CMD_W-1:0] CMD_BSOFT = 4'd8;

	typedef struct packed {
		logic [CMD_W-1:0] op;
		logic             rd_en;
		logic             rd_back;
	} cse_cmd_t;

	typedef struct packed {
		logic kind;
		logic idx_at_m;
		logic idx_at_e;
		logic e_zero;
		logic b_drop;
		logic seen;
		logic at_lastk;
		logic out_free;
	} cse_stat_t;

endpackage

>>> hdl/cse_in_if.sv
interface cse_in_if import cse_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             kind;
	logic [LEN_W-1:0] clip_count;
	logic [POS_W-1:0] left_pos;
	logic [OP_W-1:0]  op;
	logic [LEN_W-1:0] op_length;
	logic             last;

	modport source (output valid, kind, clip_count, left_pos, op, op_length, last,
		input ready);
	modport sink (input valid, kind, clip_count, left_pos, op, op_length, last,
		output ready);
endinterface

>>> hdl/cse_out_if.sv
interface cse_out_if import cse_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  out_op;
	logic [LEN_W-1:0] out_length;
	logic [POS_W-1:0] new_left;
	logic             out_last;

	modport source (output valid, out_op, out_length, new_left, out_last, input ready);
	modport sink (input valid, out_op, out_length, new_left, out_last, output ready);
endinterface

>>> hdl/cse_dp.sv
module cse_dp import cse_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cse_cmd_t         cmd,
	output cse_stat_t        stat,
	input  logic             in_kind,
	input  logic [LEN_W-1:0] in_clip_count,
	input  logic [POS_W-1:0] in_left_pos,
	input  logic [OP_W-1:0]  in_op,
	input  logic [LEN_W-1:0] in_op_length,
	input  logic             in_last,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OP_W-1:0]  out_op,
	output logic [LEN_W-1:0] out_length,
	output logic [POS_W-1:0] new_left,
	output logic             out_last
);

	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

	logic [OP_W-1:0]  mem_op  [MAX_ELEMENTS];
	logic [LEN_W-1:0] mem_len [MAX_ELEMENTS];

	logic [CW-1:0]    count_q, m_q, idx_q, e_q, f_q, lastk_q;
	logic             kind_q, first_q, seen_q, mod_q;
	logic [LEN_W-1:0] n_q, nf_q, sc_q, modlen_q;
	logic [POS_W-1:0] left_q;
	logic [OP_W-1:0]  rd_op_q;
	logic [LEN_W-1:0] rd_len_q;

	logic             out_valid_q, out_last_q;
	logic [OP_W-1:0]  out_op_q;
	logic [LEN_W-1:0] out_len_q;
	logic [POS_W-1:0] out_left_q;

	logic [CW-1:0]    e_dec;
	logic [AW-1:0]    rd_addr;
	logic             is_m, is_i, is_dn, n_pos, gt;
	logic [LEN_W-1:0] l_minus_n, n_minus_l;

	logic             f_keep;
	logic [LEN_W-1:0] f_klen, f_sc_add, f_n_nx;
	logic [LEN_W-1:0] f_left_add;

	logic             b_drop, b_mod;
	logic [LEN_W-1:0] b_sc_add, b_n_nx;

	logic [LEN_W-1:0] sc_add;
	logic [LEN_W:0]   sc_sum;
	logic [LEN_W-1:0] sc_sat;
	logic [POS_W:0]   left_sum;
	logic [POS_W-1:0] left_sat;
	logic             out_load;

	assign e_dec   = e_q - CW'(1);
	assign rd_addr = cmd.rd_back ? e_dec[AW-1:0] : idx_q[AW-1:0];

	assign is_m      = (rd_op_q == OP_M);
	assign is_i      = (rd_op_q == OP_I);
	assign is_dn     = rd_op_q inside {OP_D, OP_N};
	assign n_pos     = (n_q != '0);
	assign gt        = (rd_len_q > n_q);
	assign l_minus_n = rd_len_q - n_q;
	assign n_minus_l = n_q - rd_len_q;

	// Front walk: decides whether the element survives and what it adds.
	always_comb begin
		f_keep     = 1'b0;
		f_klen     = rd_len_q;
		f_sc_add   = '0;
		f_left_add = '0;
		f_n_nx     = n_q;
		if (first_q && rd_op_q == OP_S) begin
			f_sc_add = rd_len_q;
		end else if (is_m && gt) begin
			f_keep     = 1'b1;
			f_klen     = l_minus_n;
			f_sc_add   = n_q;
			f_left_add = n_q;
			f_n_nx     = '0;
		end else if (is_m) begin
			f_sc_add   = rd_len_q;
			f_left_add = rd_len_q;
			f_n_nx     = n_minus_l;
		end else if (is_dn && n_pos) begin
			f_left_add = rd_len_q;
		end else if (is_i && n_pos) begin
			f_sc_add = rd_len_q;
		end else begin
			f_keep = 1'b1;
			// Kept gaps and insertions ahead of the first real element are stripped.
			if (!seen_q && is_i) begin
				f_sc_add = rd_len_q;
			end
			if (!seen_q && is_dn) begin
				f_left_add = rd_len_q;
			end
		end
	end

	// Back walk: one element from the end per step.
	always_comb begin
		b_drop   = 1'b0;
		b_mod    = 1'b0;
		b_sc_add = '0;
		b_n_nx   = n_q;
		if (first_q && rd_op_q == OP_S) begin
			b_drop   = 1'b1;
			b_sc_add = rd_len_q;
		end else if (n_pos) begin
			if (is_m && gt) begin
				b_mod    = 1'b1;
				b_sc_add = n_q;
				b_n_nx   = '0;
			end else if (is_m) begin
				b_drop   = 1'b1;
				b_sc_add = rd_len_q;
				b_n_nx   = n_minus_l;
			end else begin
				b_drop   = 1'b1;
				b_sc_add = is_i ? rd_len_q : '0;
			end
		end else if (is_i || is_dn) begin
			b_drop   = 1'b1;
			b_sc_add = is_i ? rd_len_q : '0;
		end
	end

	assign sc_add   = kind_q ? b_sc_add : f_sc_add;
	assign sc_sum   = {1'b0, sc_q} + {1'b0, sc_add};
	assign sc_sat   = sc_sum[LEN_W] ? LEN_MAX : sc_sum[LEN_W-1:0];
	assign left_sum = {1'b0, left_q} + (POS_W + 1)'(f_left_add);
	assign left_sat = left_sum[POS_W] ? POS_MAX : left_sum[POS_W-1:0];

	// Element store: written while loading, read at one address a cycle.
	always_ff @(posedge clk) begin
		if (cmd.op == CMD_LOAD && count_q < CW'(MAX_ELEMENTS)) begin
			mem_op[count_q[AW-1:0]]  <= in_op;
			mem_len[count_q[AW-1:0]] <= in_op_length;
		end
		if (cmd.rd_en) begin
			rd_op_q  <= mem_op[rd_addr];
			rd_len_q <= mem_len[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			m_q     <= '0;
			idx_q   <= '0;
			e_q     <= '0;
			f_q     <= '0;
			lastk_q <= '0;
			kind_q  <= 1'b0;
			first_q <= 1'b0;
			seen_q  <= 1'b0;
			mod_q   <= 1'b0;
		end else begin
			case (cmd.op)
				CMD_LOAD: begin
					if (count_q < CW'(MAX_ELEMENTS)) begin
						count_q <= count_q + CW'(1);
					end
					if (in_last) begin
						kind_q <= in_kind;
					end
				end
				CMD_INIT: begin
					m_q     <= count_q;
					e_q     <= count_q;
					count_q <= '0;
					idx_q   <= '0;
					first_q <= 1'b1;
					seen_q  <= 1'b0;
					mod_q   <= 1'b0;
				end
				CMD_FSTEP: begin
					first_q <= 1'b0;
					idx_q   <= idx_q + CW'(1);
					if (f_keep) begin
						lastk_q <= idx_q;
						if (!seen_q && !(is_i || is_dn)) begin
							seen_q <= 1'b1;
							f_q    <= idx_q;
						end
					end
				end
				CMD_FSOFT: begin
					idx_q <= f_q;
				end
				CMD_FEMIT, CMD_BEMIT: begin
					idx_q <= idx_q + CW'(1);
				end
				CMD_BSTEP: begin
					first_q <= 1'b0;
					if (b_drop) begin
						e_q <= e_dec;
					end
					if (b_mod) begin
						mod_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Walk payload registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_LOAD: begin
				if (in_last) begin
					n_q    <= in_clip_count;
					left_q <= in_left_pos;
				end
			end
			CMD_INIT: begin
				sc_q <= '0;
			end
			CMD_FSTEP: begin
				sc_q   <= sc_sat;
				left_q <= left_sat;
				n_q    <= f_n_nx;
				if (f_keep && !seen_q && !(is_i || is_dn)) begin
					nf_q <= n_q;
				end
			end
			CMD_FSOFT: begin
				n_q <= nf_q;
			end
			CMD_FEMIT: begin
				n_q <= f_n_nx;
			end
			CMD_BSTEP: begin
				sc_q <= sc_sat;
				n_q  <= b_n_nx;
				if (b_mod) begin
					modlen_q <= l_minus_n;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	assign out_load = (cmd.op == CMD_FSOFT) || (cmd.op == CMD_BSOFT) ||
		(cmd.op == CMD_BEMIT) || (cmd.op == CMD_FEMIT && f_keep);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_left_q <= left_q;
			case (cmd.op)
				CMD_FSOFT: begin
					out_op_q   <= OP_S;
					out_len_q  <= sc_q;
					out_last_q <= !seen_q;
				end
				CMD_BSOFT: begin
					out_op_q   <= OP_S;
					out_len_q  <= sc_q;
					out_last_q <= 1'b1;
				end
				CMD_FEMIT: begin
					out_op_q   <= rd_op_q;
					out_len_q  <= f_klen;
					out_last_q <= (idx_q == lastk_q);
				end
				default: begin
					out_op_q   <= rd_op_q;
					out_len_q  <= (mod_q && idx_q == e_dec) ? modlen_q : rd_len_q;
					out_last_q <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_op     = out_op_q;
	assign out_length = out_len_q;
	assign new_left   = out_left_q;
	assign out_last   = out_last_q;

	assign stat.kind     = kind_q;
	assign stat.idx_at_m = (idx_q == m_q);
	assign stat.idx_at_e = (idx_q == e_q);
	assign stat.e_zero   = (e_q == '0);
	assign stat.b_drop   = b_drop;
	assign stat.seen     = seen_q;
	assign stat.at_lastk = (idx_q == lastk_q);
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

>>> hdl/cse_ctrl.sv
module cse_ctrl import cse_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_last,
	output logic      in_ready,
	input  cse_stat_t stat,
	output cse_cmd_t  cmd
);

	localparam logic [3:0] S_LOAD  = 4'd0;
	localparam logic [3:0] S_INIT  = 4'd1;
	localparam logic [3:0] S_F_RD  = 4'd2;
	localparam logic [3:0] S_F_EX  = 4'd3;
	localparam logic [3:0] S_F_SC  = 4'd4;
	localparam logic [3:0] S_F_ERD = 4'd5;
	localparam logic [3:0] S_F_EEX = 4'd6;
	localparam logic [3:0] S_B_RD  = 4'd7;
	localparam logic [3:0] S_B_EX  = 4'd8;
	localparam logic [3:0] S_B_ERD = 4'd9;
	localparam logic [3:0] S_B_EEX = 4'd10;
	localparam logic [3:0] S_B_SC  = 4'd11;

	logic [3:0] state_q, state_nx;

	always_comb begin
		state_nx    = state_q;
		in_ready    = 1'b0;
		cmd.op      = CMD_NONE;
		cmd.rd_en   = 1'b0;
		cmd.rd_back = 1'b0;
		case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = CMD_LOAD;
					if (in_last) begin
						state_nx = S_INIT;
					end
				end
			end
			S_INIT: begin
				cmd.op   = CMD_INIT;
				state_nx = stat.kind ? S_B_RD : S_F_RD;
			end
			S_F_RD: begin
				if (stat.idx_at_m) begin
					state_nx = S_F_SC;
				end else begin
					cmd.rd_en = 1'b1;
					state_nx  = S_F_EX;
				end
			end
			S_F_EX: begin
				cmd.op   = CMD_FSTEP;
				state_nx = S_F_RD;
			end
			S_F_SC: begin
				if (stat.out_free) begin
					cmd.op   = CMD_FSOFT;
					state_nx = stat.seen ? S_F_ERD : S_LOAD;
				end
			end
			S_F_ERD: begin
				cmd.rd_en = 1'b1;
				state_nx  = S_F_EEX;
			end
			S_F_EEX: begin
				if (stat.out_free) begin
					cmd.op   = CMD_FEMIT;
					state_nx = stat.at_lastk ? S_LOAD : S_F_ERD;
				end
			end
			S_B_RD: begin
				if (stat.e_zero) begin
					state_nx = S_B_ERD;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_back = 1'b1;
					state_nx    = S_B_EX;
				end
			end
			S_B_EX: begin
				cmd.op   = CMD_BSTEP;
				state_nx = stat.b_drop ? S_B_RD : S_B_ERD;
			end
			S_B_ERD: begin
				if (stat.idx_at_e) begin
					state_nx = S_B_SC;
				end else begin
					cmd.rd_en = 1'b1;
					state_nx  = S_B_EEX;
				end
			end
			S_B_EEX: begin
				if (stat.out_free) begin
					cmd.op   = CMD_BEMIT;
					state_nx = S_B_ERD;
				end
			end
			S_B_SC: begin
				if (stat.out_free) begin
					cmd.op   = CMD_BSOFT;
					state_nx = S_LOAD;
				end
			end
			default: begin
				state_nx = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

>>> hdl/cigar_soft_clip_editor.sv
// CIGAR soft-clip editor.
// The elem channel takes one CIGAR element (op, op_length) per transfer, one
// transfer per cycle while loading. kind, clip_count and left_pos are taken from
// the transfer marked last, which also starts the clip. Elements beyond
// MAX_ELEMENTS are ignored.
// The result channel then gives the new CIGAR, one element per transfer, with
// the soft clip first for a front clip and last for a back clip; new_left is the
// same on every transfer of one read and out_last marks the final one.
// Sequence for one read: a front clip passes a set-up step, then reads and
// walks each stored element in turn and makes an end check before the soft clip
// enters the output register; then it reads and emits each element from the first
// surviving one to the last. A back clip passes a set-up step, then reads and
// walks elements from the end until one survives, with one more check if it reaches
// the start, then reads and emits each remaining element, makes an end check and
// gives the soft clip. The element store has a single read port; each element
// is read in one state and used in the next.
// A result waits in an output register; while the receiver stalls, emission
// holds and loading of the next read may already start once the last result of
// the previous read sits in that register.
// Reset empties the element store's fill count and drops any pending result.
module cigar_soft_clip_editor import cse_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	cse_in_if.sink   elem,
	cse_out_if.source result
);

	cse_cmd_t  cmd;
	cse_stat_t stat;
	logic      in_ready;

	assign elem.ready = in_ready;

	// Sequencer: decides load, walk and emission steps.
	cse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (elem.valid),
		.in_last  (elem.last),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Element store, clip arithmetic and output register.
	cse_dp #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_kind       (elem.kind),
		.in_clip_count (elem.clip_count),
		.in_left_pos   (elem.left_pos),
		.in_op         (elem.op),
		.in_op_length  (elem.op_length),
		.in_last       (elem.last),
		.out_valid     (result.valid),
		.out_ready     (result.ready),
		.out_op        (result.out_op),
		.out_length    (result.out_length),
		.new_left      (result.new_left),
		.out_last      (result.out_last)
	);

endmodule
